[design/tbs_pkg.sv]
// Package for the terrain block sampler: request and response types, register
// indexes, fixed-point constants and the fraction blend function.
// Depends on nothing; used by terrain_block_sampler.
package tbs_pkg;

   // Field widths and fixed-point formats.
   localparam int COORD_BITS = 24;
   localparam int FRAC_BITS  = 24;
   localparam int SCALE_FRAC = 24;
   localparam int SCALE_W    = 26;
   localparam int PROD_W     = SCALE_FRAC + 32;
   localparam int SUM_W      = FRAC_BITS + 18;
   localparam int HR_W       = SUM_W - (FRAC_BITS + 8);
   localparam int LAT        = 9;

   // Hash multipliers.
   localparam logic [31:0] MUL_X    = 32'd374761393;
   localparam logic [31:0] MUL_Z    = 32'd668265263;
   localparam logic [31:0] MUL_SEED = 32'd982451653;
   localparam logic [31:0] MUL_MIX  = 32'd1274126177;
   localparam logic [31:0] OCT2_SEED_ADD = 32'd31;
   localparam logic [17:0] OCT2_MUL_Q16  = 18'd176947;
   localparam logic [14:0] AMP2_Q16      = 15'd22938;

   // Smoothstep constant 3.0 and unit 1.0 in the fraction format.
   localparam logic [FRAC_BITS+1:0] SMOOTH_K = (FRAC_BITS + 2)'(3) << FRAC_BITS;
   localparam logic [FRAC_BITS:0]   FRAC_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

   // Base height of eight blocks and the rounding half, in the height sum format.
   localparam logic [SUM_W-1:0] BASE_SUM  = SUM_W'(8) << (FRAC_BITS + 8);
   localparam logic [SUM_W-1:0] ROUND_SUM = SUM_W'(1) << (FRAC_BITS + 7);

   // Register reset values and the values derived from them.
   localparam logic [23:0] NOISE_SCALE_RESET  = 24'd838861;
   localparam logic [15:0] HEIGHT_SCALE_RESET = 16'd5120;
   localparam logic [10:0] SURF_MAX_RESET     = 11'd126;
   localparam logic [10:0] WATER_LEVEL_RESET  = 11'd32;
   localparam logic [SCALE_W-1:0] SCALE2_RESET =
      SCALE_W'((64'(NOISE_SCALE_RESET) * 64'(OCT2_MUL_Q16) + 64'd32768) >> 16);
   localparam logic [31:0] SEED2_MUL_RESET = 32'(64'(OCT2_SEED_ADD) * 64'(MUL_SEED));
   localparam logic [30:0] HAMP_RESET = 31'(32'(HEIGHT_SCALE_RESET) * 32'(AMP2_Q16));

   // Register indexes.
   localparam logic [2:0] CSR_SEED         = 3'd0;
   localparam logic [2:0] CSR_NOISE_SCALE  = 3'd1;
   localparam logic [2:0] CSR_HEIGHT_SCALE = 3'd2;
   localparam logic [2:0] CSR_WORLD_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_WATER_LEVEL  = 3'd4;

   // Block kinds.
   localparam logic [2:0] KIND_AIR   = 3'd0;
   localparam logic [2:0] KIND_WATER = 3'd1;
   localparam logic [2:0] KIND_SAND  = 3'd2;
   localparam logic [2:0] KIND_GRASS = 3'd3;
   localparam logic [2:0] KIND_DIRT  = 3'd4;
   localparam logic [2:0] KIND_STONE = 3'd5;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x_coord;
      logic signed [11:0]           y_coord;
      logic signed [COORD_BITS-1:0] z_coord;
   } req_type;

   typedef struct packed {
      logic [2:0]  block_kind;
      logic [10:0] surface_height;
   } rsp_type;

   // Linear blend of two fractions by a weight of at most one.
   function automatic logic [FRAC_BITS-1:0] lerp_frac(input logic [FRAC_BITS-1:0] a,
                                                      input logic [FRAC_BITS-1:0] b,
                                                      input logic [FRAC_BITS:0]   s);
      logic [2*FRAC_BITS+1:0] acc;
      acc = (2*FRAC_BITS + 2)'(a) * (2*FRAC_BITS + 2)'(FRAC_ONE - s)
          + (2*FRAC_BITS + 2)'(b) * (2*FRAC_BITS + 2)'(s);
      return acc[2*FRAC_BITS-1:FRAC_BITS];
   endfunction

endpackage

[design/terrain_block_sampler.sv]
// Throughput: one request per cycle, every cycle; busy stays low.
// The nine stages are scaling, hash multiplies, hash sums with smoothstep, hash
// mixing, row blends, column blend, amplitude products, height sum, classify.
// Reset is synchronous and active high: it clears the pipeline valid bits and
// returns the configuration registers to their defaults; data registers are not reset.
// Top level of the terrain block sampler; depends on tbs_pkg.
module terrain_block_sampler import tbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // Configuration, kept partly in pre-multiplied form.
   logic [23:0]        noise_scale_ff;
   logic [SCALE_W-1:0] scale2_ff;
   logic [31:0]        seed_mul_ff;
   logic [31:0]        seed2_mul_ff;
   logic [15:0]        hs_ff;
   logic [30:0]        hamp_ff;
   logic [10:0]        surf_max_ff;
   logic [10:0]        water_level_ff;

   // Pipeline valid bits and the y coordinate that travels with them.
   logic [LAT-1:0]     vld_ff;
   logic signed [11:0] y_ff [LAT-1];

   // Stage registers; index o is the octave, d the axis (x then z), c the corner.
   logic [31:0]          il_ff  [2][2];
   logic [FRAC_BITS-1:0] fr1_ff [2][2];
   logic [31:0]          am_ff  [2][2];
   logic [FRAC_BITS-1:0] fr2_ff [2][2];
   logic [FRAC_BITS-1:0] t2_ff  [2][2];
   logic [31:0]          h1_ff  [2][4];
   logic [FRAC_BITS:0]   s3_ff  [2][2];
   logic [31:0]          m_ff   [2][4];
   logic [FRAC_BITS:0]   s4_ff  [2][2];
   logic [FRAC_BITS-1:0] e_ff   [2];
   logic [FRAC_BITS-1:0] f_ff   [2];
   logic [FRAC_BITS:0]   sz5_ff [2];
   logic [FRAC_BITS-1:0] n_ff   [2];
   logic [FRAC_BITS+15:0] p0_ff;
   logic [FRAC_BITS+30:0] p1_ff;
   logic [HR_W-1:0]      hr_ff;
   rsp_type              rsp_ff;

   // Next values.
   logic [31:0]          il_in  [2][2];
   logic [FRAC_BITS-1:0] fr1_in [2][2];
   logic [31:0]          am_in  [2][2];
   logic [FRAC_BITS-1:0] t2_in  [2][2];
   logic [31:0]          h1_in  [2][4];
   logic [FRAC_BITS:0]   s3_in  [2][2];
   logic [31:0]          m_in   [2][4];
   logic [FRAC_BITS-1:0] e_in   [2];
   logic [FRAC_BITS-1:0] f_in   [2];
   logic [FRAC_BITS-1:0] n_in   [2];
   logic [FRAC_BITS+15:0] p0_in;
   logic [FRAC_BITS+30:0] p1_in;
   logic [HR_W-1:0]      hr_in;
   rsp_type              rsp_in;

   logic [SCALE_W-1:0] scl [2];
   logic [31:0]        smul [2];
   logic               accept;

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_data  = rsp_ff;

   assign scl[0]  = SCALE_W'(noise_scale_ff);
   assign scl[1]  = scale2_ff;
   assign smul[0] = seed_mul_ff;
   assign smul[1] = seed2_mul_ff;

   // Configuration writes; the second-octave terms are derived as they are written.
   always_ff @(posedge clock) begin
      if (reset) begin
         noise_scale_ff <= NOISE_SCALE_RESET;
         scale2_ff      <= SCALE2_RESET;
         seed_mul_ff    <= '0;
         seed2_mul_ff   <= SEED2_MUL_RESET;
         hs_ff          <= HEIGHT_SCALE_RESET;
         hamp_ff        <= HAMP_RESET;
         surf_max_ff    <= SURF_MAX_RESET;
         water_level_ff <= WATER_LEVEL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SEED: begin
               seed_mul_ff  <= csr_wdata * MUL_SEED;
               seed2_mul_ff <= (csr_wdata + OCT2_SEED_ADD) * MUL_SEED;
            end
            CSR_NOISE_SCALE: begin
               noise_scale_ff <= csr_wdata[23:0];
               scale2_ff <= SCALE_W'((43'(csr_wdata[23:0]) * 43'(OCT2_MUL_Q16)
                                      + 43'd32768) >> 16);
            end
            CSR_HEIGHT_SCALE: begin
               hs_ff   <= csr_wdata[15:0];
               hamp_ff <= 31'(csr_wdata[15:0]) * 31'(AMP2_Q16);
            end
            CSR_WORLD_HEIGHT: begin
               surf_max_ff <= (csr_wdata[11:0] >= 12'd3) ?
                              11'(csr_wdata[11:0] - 12'd2) : 11'd1;
            end
            CSR_WATER_LEVEL: begin
               water_level_ff <= csr_wdata[10:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Stage one: scale both coordinates for both octaves into lattice index and fraction.
   always_comb begin : s1_comb
      logic signed [COORD_BITS-1:0] cs;
      logic signed [PROD_W-1:0]     pr;
      cs = '0;
      pr = '0;
      for (int o = 0; o < 2; o++) begin
         for (int d = 0; d < 2; d++) begin
            cs = (d == 0) ? req_data.x_coord : req_data.z_coord;
            pr = cs * $signed({1'b0, scl[o]});
            il_in[o][d]  = pr[SCALE_FRAC +: 32];
            fr1_in[o][d] = pr[SCALE_FRAC-1 -: FRAC_BITS];
         end
      end
   end

   // Stage two: lattice index products of the hash and the squared fraction.
   always_comb begin : s2_comb
      logic [2*FRAC_BITS-1:0] sq;
      sq = '0;
      for (int o = 0; o < 2; o++) begin
         for (int d = 0; d < 2; d++) begin
            am_in[o][d] = il_ff[o][d] * ((d == 0) ? MUL_X : MUL_Z);
            sq = fr1_ff[o][d] * fr1_ff[o][d];
            t2_in[o][d] = sq[2*FRAC_BITS-1:FRAC_BITS];
         end
      end
   end

   // Stage three: hash sums of the four corners and the smoothstep weights.
   always_comb begin : s3_comb
      logic [31:0]            n;
      logic [FRAC_BITS+1:0]   k;
      logic [2*FRAC_BITS+1:0] pr;
      n  = '0;
      k  = '0;
      pr = '0;
      for (int o = 0; o < 2; o++) begin
         for (int c = 0; c < 4; c++) begin
            n = am_ff[o][0] + (c[0] ? MUL_X : 32'd0)
              + am_ff[o][1] + (c[1] ? MUL_Z : 32'd0) + smul[o];
            h1_in[o][c] = n ^ (n >> 13);
         end
         for (int d = 0; d < 2; d++) begin
            k  = SMOOTH_K - {1'b0, fr2_ff[o][d], 1'b0};
            pr = (2*FRAC_BITS + 2)'(t2_ff[o][d]) * (2*FRAC_BITS + 2)'(k);
            s3_in[o][d] = pr[2*FRAC_BITS:FRAC_BITS];
         end
      end
   end

   // Stage four: the mixing multiply of the hash.
   always_comb begin : s4_comb
      for (int o = 0; o < 2; o++) begin
         for (int c = 0; c < 4; c++) begin
            m_in[o][c] = h1_ff[o][c] * MUL_MIX;
         end
      end
   end

   // Stage five: fold the hash into corner values and blend along x.
   always_comb begin : s5_comb
      logic [31:0]          v;
      logic [FRAC_BITS-1:0] cv [4];
      v = '0;
      for (int c = 0; c < 4; c++) begin
         cv[c] = '0;
      end
      for (int o = 0; o < 2; o++) begin
         for (int c = 0; c < 4; c++) begin
            v = m_ff[o][c] ^ (m_ff[o][c] >> 16);
            cv[c] = v[23 -: FRAC_BITS];
         end
         e_in[o] = lerp_frac(cv[0], cv[1], s4_ff[o][0]);
         f_in[o] = lerp_frac(cv[2], cv[3], s4_ff[o][0]);
      end
   end

   // Stage six: blend along z into the octave's noise value.
   always_comb begin : s6_comb
      for (int o = 0; o < 2; o++) begin
         n_in[o] = lerp_frac(e_ff[o], f_ff[o], sz5_ff[o]);
      end
   end

   // Stage seven: scale both octaves by their amplitudes.
   assign p0_in = (FRAC_BITS + 16)'(n_ff[0]) * (FRAC_BITS + 16)'(hs_ff);
   assign p1_in = (FRAC_BITS + 31)'(n_ff[1]) * (FRAC_BITS + 31)'(hamp_ff);

   // Stage eight: add the base height and round to whole blocks.
   always_comb begin : s8_comb
      logic [SUM_W-1:0] sum;
      sum = BASE_SUM + SUM_W'(p0_ff) + SUM_W'(p1_ff >> 16) + ROUND_SUM;
      hr_in = sum[SUM_W-1:FRAC_BITS+8];
   end

   // Stage nine: clamp the surface and classify the voxel.
   always_comb begin : s9_comb
      logic [10:0]        h;
      logic signed [12:0] ys;
      logic signed [12:0] hsg;
      logic signed [12:0] wls;
      h = (11'(hr_ff) > surf_max_ff) ? surf_max_ff : 11'(hr_ff);
      if (h < 11'd1) begin
         h = 11'd1;
      end
      ys  = 13'(y_ff[LAT-2]);
      hsg = $signed({2'b00, h});
      wls = $signed({2'b00, water_level_ff});
      if (ys > hsg) begin
         rsp_in.block_kind = (ys <= wls) ? KIND_WATER : KIND_AIR;
      end else if (ys == hsg) begin
         rsp_in.block_kind = (hsg <= wls + 13'sd1) ? KIND_SAND : KIND_GRASS;
      end else if (ys > hsg - 13'sd4) begin
         rsp_in.block_kind = KIND_DIRT;
      end else begin
         rsp_in.block_kind = KIND_STONE;
      end
      rsp_in.surface_height = h;
   end

   // Valid bits advance every cycle; the receiver takes each response as shown.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], accept};
      end
   end

   // Data registers of all stages.
   always_ff @(posedge clock) begin
      y_ff[0] <= req_data.y_coord;
      for (int i = 1; i < LAT - 1; i++) begin
         y_ff[i] <= y_ff[i-1];
      end
      il_ff  <= il_in;
      fr1_ff <= fr1_in;
      am_ff  <= am_in;
      fr2_ff <= fr1_ff;
      t2_ff  <= t2_in;
      h1_ff  <= h1_in;
      s3_ff  <= s3_in;
      m_ff   <= m_in;
      s4_ff  <= s3_ff;
      e_ff   <= e_in;
      f_ff   <= f_in;
      for (int o = 0; o < 2; o++) begin
         sz5_ff[o] <= s4_ff[o][1];
      end
      n_ff   <= n_in;
      p0_ff  <= p0_in;
      p1_ff  <= p1_in;
      hr_ff  <= hr_in;
      rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   // Every accepted request gives a response.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##9 rsp_valid)
      else $error("request did not produce a response after nine cycles");

   // No response appears without a matching earlier request.
   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 9))
      else $error("response without a matching request");

   // The surface lies within the clamp range.
   a_surface_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.surface_height >= 11'd1
                     && rsp_data.surface_height <= surf_max_ff))
      else $error("surface height outside the clamp range");

   // The block kind is one of the six defined kinds.
   a_kind_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.block_kind <= KIND_STONE))
      else $error("undefined block kind");
`endif

endmodule
